// ===== src/lsc_pkg.sv =====
// ----------------------------------------------------------------------------
// lsc_pkg: shared definitions for the LRU set-associative cache model
// Codes, field widths and the access result record used by the cache modules.
// ----------------------------------------------------------------------------
package lsc_pkg;

  // Default sizing of the line storage.
  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;

  // Fixed field widths.
  localparam int TAG_W  = 63;
  localparam int ADDR_W = 64;
  localparam int CNT_W  = 32;

  // Request kinds.
  localparam logic [1:0] REQ_LOAD   = 2'd0;
  localparam logic [1:0] REQ_STORE  = 2'd1;
  localparam logic [1:0] REQ_MODIFY = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // Access outcomes.
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  // Outcome of one access, handed from the update logic to the control.
  typedef struct packed {
    logic       hit;
    logic       miss;
    logic       evict;
    logic [1:0] outcome;
  } acc_res_t;

endpackage

// ===== src/lru_set_assoc_cache_sim_unit.sv =====
// ----------------------------------------------------------------------------
// lru_set_assoc_cache_sim_unit: LRU set-associative cache hit/miss model
// Looks up each load, store or modify request in a set-wide tag memory and counts the outcomes.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake          Payload
// s_*      in   s_tvalid/s_tready  tdata address, tuser request kind
// m_*      out  m_tvalid/m_tready  tdata counters, tuser outcome, tlast
// cfg_*    in   cfg_valid/cfg_ready cfg_index, cfg_data
//
// A load or store is handled in an accept cycle, which also reads the set
// memory, and an update cycle in S_LOOK, at whose end the result is registered.
// A modify adds a second access in S_SECOND, which works on the row just
// written. The registered memory read and the single update unit set this
// sequence. Reset clears the per-set valid flags; no clearing pass. A stalled
// result holds the unit before its update.
// ----------------------------------------------------------------------------
module lru_set_assoc_cache_sim_unit #(
  parameter int MAX_SET_BITS = lsc_pkg::MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = lsc_pkg::MAX_WAYS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // address
  input  logic [1:0]  s_tuser,   // req_type
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // hits_total, misses_total, evictions_total
  output logic [1:0]  m_tuser,   // outcome
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int SETS    = 2 ** MAX_SET_BITS;
  localparam int RW      = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int WAYS_CW = $clog2(MAX_WAYS + 1) > 4 ? $clog2(MAX_WAYS + 1) : 4;
  localparam int ROW_W   = MAX_WAYS * (lsc_pkg::TAG_W + RW + 1);
  localparam int SB_CW   = 4;
  localparam int SET_W   = MAX_SET_BITS;

  typedef enum logic [1:0] {S_IDLE, S_LOOK, S_SECOND} state_t;

  state_t                    state;
  logic [2:0]                set_bits;
  logic [5:0]                block_bits;
  logic [3:0]                ways_in_use;
  logic [SET_W-1:0]          cur_set;
  logic [lsc_pkg::TAG_W-1:0] cur_tag;
  logic                      cur_mod;
  logic [ROW_W-1:0]          fwd_row;
  logic [lsc_pkg::CNT_W-1:0] hits;
  logic [lsc_pkg::CNT_W-1:0] misses;
  logic [lsc_pkg::CNT_W-1:0] evicts;

  logic [SB_CW-1:0]          sb;
  logic [6:0]                sh;
  logic [63:0]               shifted;
  logic [SET_W-1:0]          set_mask;
  logic [SET_W-1:0]          in_set;
  logic [lsc_pkg::TAG_W-1:0] in_tag;
  logic [WAYS_CW-1:0]        ways;
  logic                      in_beat;
  logic                      out_free;
  logic                      do_acc;
  logic [ROW_W-1:0]          mem_row;
  logic [ROW_W-1:0]          cur_row;
  logic [ROW_W-1:0]          new_row;
  lsc_pkg::acc_res_t         res;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      set_bits    <= 3'd4;
      block_bits  <= 6'd4;
      ways_in_use <= 4'd1;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        lsc_pkg::REG_SET_BITS:   set_bits    <= cfg_data[2:0];
        lsc_pkg::REG_BLOCK_BITS: block_bits  <= cfg_data;
        lsc_pkg::REG_WAYS:       ways_in_use <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Address split into set index and tag.
  always_comb begin
    sb = (SB_CW'(set_bits) > SB_CW'(MAX_SET_BITS)) ? SB_CW'(MAX_SET_BITS)
                                                   : SB_CW'(set_bits);
    sh       = 7'(block_bits) + 7'(sb);
    shifted  = s_tdata >> block_bits;
    set_mask = ~({SET_W{1'b1}} << sb);
    in_set   = shifted[SET_W-1:0] & set_mask;
    in_tag   = (sh >= 7'd64) ? '0 : lsc_pkg::TAG_W'(s_tdata >> sh);
  end

  // Clamp the way count to one through the storage depth.
  always_comb begin
    if (ways_in_use == 4'd0) begin
      ways = WAYS_CW'(1);
    end else if (WAYS_CW'(ways_in_use) > WAYS_CW'(MAX_WAYS)) begin
      ways = WAYS_CW'(MAX_WAYS);
    end else begin
      ways = WAYS_CW'(ways_in_use);
    end
  end

  assign s_tready = (state == S_IDLE);
  assign in_beat  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign do_acc   = (state != S_IDLE) && out_free;
  assign cur_row  = (state == S_SECOND) ? fwd_row : mem_row;

  lsc_tag_store #(
    .SETS  (SETS),
    .ROW_W (ROW_W)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_beat),
    .rd_addr (in_set),
    .rd_row  (mem_row),
    .wr_en   (do_acc),
    .wr_addr (cur_set),
    .wr_row  (new_row)
  );

  lsc_access #(
    .MAX_WAYS (MAX_WAYS),
    .RW       (RW),
    .WAYS_CW  (WAYS_CW),
    .ROW_W    (ROW_W)
  ) u_access (
    .row_in  (cur_row),
    .tag     (cur_tag),
    .ways    (ways),
    .row_out (new_row),
    .res     (res)
  );

  // Sequencer, counters and the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
      hits     <= '0;
      misses   <= '0;
      evicts   <= '0;
    end else begin
      if (m_tready && !do_acc) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_beat && s_tuser != lsc_pkg::REQ_NONE) begin
            state   <= S_LOOK;
            cur_set <= in_set;
            cur_tag <= in_tag;
            cur_mod <= (s_tuser == lsc_pkg::REQ_MODIFY);
          end
        end
        S_LOOK, S_SECOND: begin
          if (do_acc) begin
            state   <= (state == S_LOOK && cur_mod) ? S_SECOND : S_IDLE;
            fwd_row <= new_row;
            if (res.hit && hits != '1) begin
              hits <= hits + 1'b1;
            end
            if (res.miss && misses != '1) begin
              misses <= misses + 1'b1;
            end
            if (res.evict && evicts != '1) begin
              evicts <= evicts + 1'b1;
            end
            m_tvalid <= 1'b1;
            m_tuser  <= res.outcome;
            m_tlast  <= !(state == S_LOOK && cur_mod);
            m_tdata  <= {evicts + 32'(res.evict && evicts != '1),
                         misses + 32'(res.miss && misses != '1),
                         hits + 32'(res.hit && hits != '1)};
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The first result of a modify is only shown while its second access waits.
  a_first_pending: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (state == S_SECOND))
    else $error("first modify result without pending second access");

  // Evictions are a subset of misses.
  a_evict_le_miss: assert property (@(posedge clk) disable iff (rst)
    evicts <= misses)
    else $error("eviction count exceeds miss count");

  // An eviction result always follows a counted eviction.
  a_evict_counted: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == lsc_pkg::OUT_EVICT) |-> (evicts != '0))
    else $error("eviction reported with zero eviction count");

  // No new request is taken while an access is under way.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOK && !out_free) |=> (state == S_LOOK && !s_tready))
    else $error("access left before its result could be stored");

endmodule

// ===== src/lsc_tag_store.sv =====
// ----------------------------------------------------------------------------
// lsc_tag_store: set-wide line memory
// One row per set holds every way. Rows not yet written read as zero.
// ----------------------------------------------------------------------------
module lsc_tag_store #(
  parameter int SETS  = 64,
  parameter int ROW_W = 536
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    rd_en,
  input  logic [$clog2(SETS)-1:0] rd_addr,
  output logic [ROW_W-1:0]        rd_row,
  input  logic                    wr_en,
  input  logic [$clog2(SETS)-1:0] wr_addr,
  input  logic [ROW_W-1:0]        wr_row
);

  logic [ROW_W-1:0] mem [SETS];
  logic [SETS-1:0]  row_vld;
  logic [ROW_W-1:0] rd_data;
  logic             rd_vld;

  // Memory array with a registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_row;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Row valid flags give the cleared state right after reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= row_vld[rd_addr];
      end
    end
  end

  assign rd_row = rd_vld ? rd_data : '0;

endmodule

// ===== src/lsc_access.sv =====
// ----------------------------------------------------------------------------
// lsc_access: one cache access on a set row
// Tag lookup, fill or victim choice, and the LRU rank update.
// ----------------------------------------------------------------------------
module lsc_access #(
  parameter int MAX_WAYS = 8,
  parameter int RW       = 3,
  parameter int WAYS_CW  = 4,
  parameter int ROW_W    = 536
) (
  input  logic [ROW_W-1:0]          row_in,
  input  logic [lsc_pkg::TAG_W-1:0] tag,
  input  logic [WAYS_CW-1:0]        ways,
  output logic [ROW_W-1:0]          row_out,
  output lsc_pkg::acc_res_t         res
);

  localparam int WAY_W = lsc_pkg::TAG_W + RW + 1;
  localparam logic [RW-1:0] MAX_RANK = RW'(MAX_WAYS - 1);

  logic [lsc_pkg::TAG_W-1:0] w_tag  [MAX_WAYS];
  logic [RW-1:0]             w_rank [MAX_WAYS];
  logic [MAX_WAYS-1:0]       w_vld;
  logic [MAX_WAYS-1:0]       w_use;
  logic                      hit_any;
  logic                      inv_any;
  logic [RW-1:0]             hit_way;
  logic [RW-1:0]             inv_way;
  logic [RW-1:0]             victim;
  logic [RW-1:0]             sel;
  logic                      sel_vld;
  logic [RW-1:0]             limit;

  // Unpack the row and mark the ways in use.
  always_comb begin
    for (int i = 0; i < MAX_WAYS; i++) begin
      w_tag[i]  = row_in[i*WAY_W +: lsc_pkg::TAG_W];
      w_rank[i] = row_in[i*WAY_W + lsc_pkg::TAG_W +: RW];
      w_vld[i]  = row_in[i*WAY_W + lsc_pkg::TAG_W + RW];
      w_use[i]  = WAYS_CW'(i) < ways;
    end
  end

  // Lowest hitting way, lowest empty way, and the least recent way.
  always_comb begin
    hit_any = 1'b0;
    inv_any = 1'b0;
    hit_way = '0;
    inv_way = '0;
    victim  = '0;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (!hit_any && w_use[i] && w_vld[i] && w_tag[i] == tag) begin
        hit_any = 1'b1;
        hit_way = RW'(i);
      end
      if (!inv_any && w_use[i] && !w_vld[i]) begin
        inv_any = 1'b1;
        inv_way = RW'(i);
      end
      if (i > 0 && w_use[i] && w_rank[i] > w_rank[victim]) begin
        victim = RW'(i);
      end
    end
  end

  // Pick the way to touch and report what happened.
  always_comb begin
    priority if (hit_any) begin
      sel = hit_way;
      res = '{hit: 1'b1, miss: 1'b0, evict: 1'b0, outcome: lsc_pkg::OUT_HIT};
    end else if (inv_any) begin
      sel = inv_way;
      res = '{hit: 1'b0, miss: 1'b1, evict: 1'b0, outcome: lsc_pkg::OUT_FILL};
    end else begin
      sel = victim;
      res = '{hit: 1'b0, miss: 1'b1, evict: 1'b1, outcome: lsc_pkg::OUT_EVICT};
    end
    sel_vld = w_vld[sel];
    limit   = w_rank[sel];
  end

  // Make the touched line most recent, writing its tag on a miss, and age the lines that were more recent than it.
  always_comb begin
    row_out = row_in;
    for (int i = 0; i < MAX_WAYS; i++) begin
      if (RW'(i) == sel) begin
        row_out[i*WAY_W + lsc_pkg::TAG_W +: RW] = '0;
        row_out[i*WAY_W + lsc_pkg::TAG_W + RW]  = 1'b1;
        if (!hit_any) begin
          row_out[i*WAY_W +: lsc_pkg::TAG_W] = tag;
        end
      end else if (w_use[i] && w_vld[i] && (!sel_vld || w_rank[i] < limit) &&
                   w_rank[i] != MAX_RANK) begin
        row_out[i*WAY_W + lsc_pkg::TAG_W +: RW] = w_rank[i] + 1'b1;
      end
    end
  end

endmodule
